// ===== hw/rtl/rom_sram_bank_mapper_assert.svh =====
// Assertion macros for the bank mapper, clocked on clk_i, disabled in reset.
`ifndef ROM_SRAM_BANK_MAPPER_ASSERT_SVH
`define ROM_SRAM_BANK_MAPPER_ASSERT_SVH

// Same-cycle implication.
`define RSBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bank mapper check failed");

// Next-cycle implication.
`define RSBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bank mapper check failed");

`endif

// ===== hw/rtl/rsbm_pkg.sv =====
// Types, constants and reset state shared by the bank mapper modules.
`timescale 1ns / 1ps
package rsbm_pkg;

  localparam int unsigned RomPages8kDefault = 16;
  localparam int unsigned SramBytes         = 8192;
  localparam int unsigned SramAddrW         = $clog2(SramBytes);
  localparam int unsigned HalfOffW          = SramAddrW - 1;
  localparam int unsigned PageW             = 4;
  localparam int unsigned RomOffW           = 13;
  localparam int unsigned RomAddrW          = PageW + RomOffW;
  localparam int unsigned NumWin            = 3;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // 4KB region codes (address bits 15:12)
  localparam logic [3:0] RegionWin1  = 4'h6;
  localparam logic [3:0] RegionWin2  = 4'h8;
  localparam logic [3:0] RegionWin3  = 4'hA;
  localparam logic [3:0] RegionStore = 4'hB;

  // 8KB window codes (address bits 15:13)
  localparam logic [2:0] AddrWin0 = 3'b010;
  localparam logic [2:0] AddrWin1 = 3'b011;
  localparam logic [2:0] AddrWin2 = 3'b100;
  localparam logic [2:0] AddrWin3 = 3'b101;

  localparam int unsigned DataSramBit = 4;
  localparam int unsigned DataHalfBit = 5;

  typedef enum logic [1:0] {
    TgtNone = 2'd0,
    TgtRom  = 2'd1,
    TgtSram = 2'd2
  } target_e;

  typedef struct packed {
    logic        cmd;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } bus_item_t;

  typedef struct packed {
    target_e                target;
    logic [RomAddrW-1:0]    rom_address;
    logic [SramAddrW-1:0]   sram_address;
    logic                   sram_write;
    logic [7:0]             sram_data;
  } map_result_t;

  typedef struct packed {
    logic [NumWin-1:0]            is_sram;
    logic [NumWin-1:0][PageW-1:0] rom_page;
    logic [NumWin-1:0]            sram_half;
    logic                         wr_half;
    logic                         wr_en;
  } bank_state_t;

  localparam bank_state_t BankStateRst = '{
    is_sram:   '0,
    rom_page:  {4'd3, 4'd2, 4'd1},
    sram_half: '0,
    wr_half:   1'b0,
    wr_en:     1'b0
  };

endpackage

// ===== hw/rtl/rsbm_decode.sv =====
// Address decode and bank register update for one bus transfer.
`timescale 1ns / 1ps
module rsbm_decode #(
  parameter int unsigned RomPages8k = rsbm_pkg::RomPages8kDefault
) (
  input  rsbm_pkg::bus_item_t   item_i,
  input  rsbm_pkg::bank_state_t state_i,
  output rsbm_pkg::bank_state_t state_o,
  output rsbm_pkg::map_result_t result_o
);
  import rsbm_pkg::*;

  localparam logic [PageW:0]   PagesLim = (PageW+1)'(RomPages8k);
  localparam logic [PageW-1:0] PageMask = PageW'(RomPages8k - 1);

  logic [NumWin-1:0] wr_sel;
  logic [NumWin-1:0] rd_sel;
  logic              rd_is_sram;
  logic              rd_half;
  logic [PageW-1:0]  rd_page;
  logic [PageW-1:0]  rd_page_m;

  // page beyond the ROM wraps through the mask
  assign rd_page_m = ({1'b0, rd_page} >= PagesLim) ? (rd_page & PageMask) : rd_page;

  always_comb begin
    wr_sel = '0;
    if (item_i.cmd == CmdWrite) begin
      case (item_i.bus_address[15:12])
        RegionWin1: wr_sel = 3'b001;
        RegionWin2: wr_sel = 3'b010;
        RegionWin3: wr_sel = 3'b100;
        default:    wr_sel = '0;
      endcase
    end
  end

  always_comb begin
    rd_sel = '0;
    case (item_i.bus_address[15:13])
      AddrWin1: rd_sel = 3'b001;
      AddrWin2: rd_sel = 3'b010;
      AddrWin3: rd_sel = 3'b100;
      default:  rd_sel = '0;
    endcase
  end

  always_comb begin
    rd_is_sram = 1'b0;
    rd_half    = 1'b0;
    rd_page    = '0;
    for (int i = 0; i < NumWin; i++) begin
      if (rd_sel[i]) begin
        rd_is_sram = state_i.is_sram[i];
        rd_half    = state_i.sram_half[i];
        rd_page    = state_i.rom_page[i];
      end
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (item_i.cmd == CmdWrite) begin
      for (int i = 0; i < NumWin; i++) begin
        if (wr_sel[i]) begin
          if (item_i.bus_data[DataSramBit]) begin
            state_o.is_sram[i]   = 1'b1;
            state_o.sram_half[i] = item_i.bus_data[DataHalfBit];
            state_o.wr_half      = item_i.bus_data[DataHalfBit];
          end else begin
            state_o.is_sram[i]  = 1'b0;
            state_o.rom_page[i] = item_i.bus_data[PageW-1:0];
          end
        end
      end
      if (wr_sel[NumWin-1]) begin
        state_o.wr_en = item_i.bus_data[DataSramBit];
      end
      if (item_i.bus_address[15:12] == RegionStore && state_i.wr_en) begin
        result_o.sram_write   = 1'b1;
        result_o.sram_address = {state_i.wr_half, item_i.bus_address[HalfOffW-1:0]};
        result_o.sram_data    = item_i.bus_data;
      end
    end else if (item_i.bus_address[15:13] == AddrWin0) begin
      result_o.target      = TgtRom;
      result_o.rom_address = {{PageW{1'b0}}, item_i.bus_address[RomOffW-1:0]};
    end else if (|rd_sel) begin
      if (rd_is_sram) begin
        result_o.target       = TgtSram;
        result_o.sram_address = {rd_half, item_i.bus_address[HalfOffW-1:0]};
      end else begin
        result_o.target      = TgtRom;
        result_o.rom_address = {rd_page_m, item_i.bus_address[RomOffW-1:0]};
      end
    end
  end

endmodule

// ===== hw/rtl/rom_sram_bank_mapper.sv =====
// Cartridge ROM/SRAM bank mapper: bank registers, decode and result register.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid_i / in_ready_o / in_item_i): one CPU bus access
//   per transfer, carrying cmd (0 read, 1 write), bus_address and bus_data.
//   Output channel (out_valid_o / out_ready_i / out_item_o): exactly one
//   result per input transfer, in order: target, rom_address, sram_address,
//   sram_write strobe and sram_data.
//   Map: 0x4000-0x5FFF is ROM page 0; 0x6000, 0x8000 and 0xA000 are
//   switchable 8KB windows, each mapping a ROM page or a 4KB SRAM half.
//   Writes to the low 4KB of a switchable window reprogram it; writes to
//   0xB000-0xBFFF store into SRAM while SRAM writes are enabled.
// Timing and throughput
//   A result appears in the next cycle. Without a stall, one transfer per
//   cycle is sustained: decode and the bank register update are a single
//   pass of logic between the input port and the result register, and the
//   bank registers are updated at the same edge, so the next access sees them.
// Reset: rst_ni clears the output valid and loads the bank registers:
//   windows map ROM pages 1, 2, 3, SRAM halves 0, SRAM writes disabled.
// Stall
//   While out_valid_o is high and out_ready_i low, the result holds and
//   in_ready_o drops; no new transfer is taken until the result is taken.
module rom_sram_bank_mapper #(
  parameter int unsigned RomPages8k = rsbm_pkg::RomPages8kDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rsbm_pkg::bus_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rsbm_pkg::map_result_t out_item_o
);
  import rsbm_pkg::*;

  `include "rom_sram_bank_mapper_assert.svh"

  bank_state_t bank_q, bank_d;
  map_result_t res_q, res_d;
  logic        res_valid_q;
  logic        in_fire;

  // result register frees up in the same cycle it is taken
  assign in_ready_o  = !res_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

  rsbm_decode #(
    .RomPages8k(RomPages8k)
  ) u_decode (
    .item_i  (in_item_i),
    .state_i (bank_q),
    .state_o (bank_d),
    .result_o(res_d)
  );

  // control: bank registers and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= BankStateRst;
      res_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        bank_q <= bank_d;
      end
      if (in_fire) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // writes never report a read target
  `RSBM_ASSERT_NEXT(a_write_no_target,
    in_fire && in_item_i.cmd == CmdWrite,
    out_valid_o && out_item_o.target == TgtNone)

  // an enabled store region write strobes SRAM with the written byte
  `RSBM_ASSERT_NEXT(a_store_strobe,
    in_fire && in_item_i.cmd == CmdWrite &&
    in_item_i.bus_address[15:12] == RegionStore && bank_q.wr_en,
    out_item_o.sram_write && out_item_o.sram_data == $past(in_item_i.bus_data))

  // the third window's select write sets the store enable
  `RSBM_ASSERT_NEXT(a_enable_update,
    in_fire && in_item_i.cmd == CmdWrite && in_item_i.bus_address[15:12] == RegionWin3,
    bank_q.wr_en == $past(in_item_i.bus_data[DataSramBit]))

  // reads below the mapped range give an all-zero result
  `RSBM_ASSERT_NEXT(a_low_unmapped,
    in_fire && in_item_i.cmd == CmdRead && in_item_i.bus_address[15:14] == 2'b00,
    out_item_o == '0)

  // back-pressure only comes from a held result
  `RSBM_ASSERT_NOW(a_ready_stall,
    !in_ready_o,
    res_valid_q && !out_ready_i)

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the cartridge ROM/SRAM bank mapper.
`timescale 1ns / 1ps
module testbench;
  import rsbm_pkg::*;

  localparam int unsigned RomPages    = RomPages8kDefault;
  localparam int unsigned NumRandom   = 1625;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  // no idling on either side inside this cycle range
  localparam int unsigned QuietFrom   = 1500;
  localparam int unsigned QuietTo     = 2300;

  typedef struct {
    bus_item_t acc;
    bit        drain_first;  // hold this access until all results are back
  } pending_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  bus_item_t   in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  map_result_t out_item_o;

  pending_t    access_q[$];
  map_result_t result_q[$];
  int unsigned cycle_count = 0;
  int unsigned err_count   = 0;
  bit          in_fire     = 1'b0;

  // Shadow bank registers, reset values
  logic       win_maps_sram [3] = '{1'b0, 1'b0, 1'b0};
  logic [3:0] win_page      [3] = '{4'd1, 4'd2, 4'd3};
  logic       win_half      [3] = '{1'b0, 1'b0, 1'b0};
  logic       store_half    = 1'b0;
  logic       store_enabled = 1'b0;

  rom_sram_bank_mapper #(
    .RomPages8k(RomPages)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Decode one bus access against the shadow banks; updates them on
  // bank select writes.
  function automatic map_result_t map_access(bus_item_t acc);
    map_result_t res;
    logic [3:0]  region;
    logic [3:0]  page;
    int unsigned w;
    res    = '0;
    res.target = TgtNone;
    region = acc.bus_address[15:12];
    if (acc.cmd == CmdWrite) begin
      // only the low 4KB of each switchable window is a bank register
      if (region inside {RegionWin1, RegionWin2, RegionWin3}) begin
        w = (region - RegionWin1) >> 1;
        if (region == RegionWin3) begin
          store_enabled = acc.bus_data[DataSramBit];
        end
        if (acc.bus_data[DataSramBit]) begin
          win_maps_sram[w] = 1'b1;
          win_half[w]      = acc.bus_data[DataHalfBit];
          store_half       = acc.bus_data[DataHalfBit];
        end else begin
          win_maps_sram[w] = 1'b0;
          win_page[w]      = acc.bus_data[3:0];
        end
      end else if (region == RegionStore && store_enabled) begin
        res.sram_write   = 1'b1;
        res.sram_address = {store_half, acc.bus_address[11:0]};
        res.sram_data    = acc.bus_data;
      end
    end else if (acc.bus_address >= 16'h4000 && acc.bus_address < 16'hC000) begin
      w = (acc.bus_address - 16'h4000) >> 13;
      if (w == 0) begin
        res.target      = TgtRom;
        res.rom_address = {4'd0, acc.bus_address[12:0]};
      end else if (win_maps_sram[w-1]) begin
        // 4KB half mirrored over the whole 8KB window
        res.target       = TgtSram;
        res.sram_address = {win_half[w-1], acc.bus_address[11:0]};
      end else begin
        page = win_page[w-1];
        if (page >= RomPages) begin
          page = page & 4'(RomPages - 1);
        end
        res.target      = TgtRom;
        res.rom_address = {page, acc.bus_address[12:0]};
      end
    end
    return res;
  endfunction

  function automatic bit idle_now();
    if (cycle_count >= QuietFrom && cycle_count < QuietTo) begin
      return 1'b0;
    end
    return $urandom_range(99) < 28;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_count++;
    $display("mismatch %0d at cycle %0d: %s got 0x%0h want 0x%0h",
             err_count, cycle_count, what, got, want);
  endtask

  task automatic add_access(logic cmd, logic [15:0] addr, logic [7:0] data, bit drain);
    pending_t p;
    p.acc.cmd         = cmd;
    p.acc.bus_address = addr;
    p.acc.bus_data    = data;
    p.drain_first     = drain;
    access_q.push_back(p);
  endtask

  // Stimulus, reset and end of run
  initial begin
    int unsigned kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        cmd;

    // unmapped edges, fixed window, and reset pages 1..3
    add_access(CmdRead,  16'h0000, 8'hFF, 1'b0);
    add_access(CmdRead,  16'h3FFF, 8'h00, 1'b0);
    add_access(CmdRead,  16'h4000, 8'h00, 1'b0);
    add_access(CmdRead,  16'h5FFF, 8'h00, 1'b0);
    add_access(CmdRead,  16'h6000, 8'h00, 1'b0);
    add_access(CmdRead,  16'h9FFF, 8'h00, 1'b0);
    add_access(CmdRead,  16'hBFFF, 8'h00, 1'b0);
    add_access(CmdRead,  16'hC000, 8'h00, 1'b0);
    add_access(CmdRead,  16'hFFFF, 8'h00, 1'b0);
    // store while SRAM writes are disabled is dropped
    add_access(CmdWrite, 16'hB000, 8'h5A, 1'b0);
    // window 3 to SRAM half 1, which enables stores
    add_access(CmdWrite, 16'hA000, 8'h30, 1'b0);
    add_access(CmdWrite, 16'hB123, 8'hA5, 1'b0);
    add_access(CmdWrite, 16'hBFFF, 8'hFF, 1'b0);
    add_access(CmdRead,  16'hA000, 8'h00, 1'b0);
    add_access(CmdRead,  16'hB800, 8'h00, 1'b0);
    // top ROM page with junk in the high data bits
    add_access(CmdWrite, 16'h6FFF, 8'hCF, 1'b0);
    add_access(CmdRead,  16'h7FFF, 8'h00, 1'b0);
    // window 2 to SRAM half 0 also moves the store half
    add_access(CmdWrite, 16'h8000, 8'h10, 1'b0);
    add_access(CmdWrite, 16'hB000, 8'h00, 1'b0);
    // writes to upper halves and outside the map do nothing
    add_access(CmdWrite, 16'h7000, 8'h3F, 1'b0);
    add_access(CmdWrite, 16'h9000, 8'h3F, 1'b0);
    add_access(CmdWrite, 16'h1234, 8'h3F, 1'b0);
    add_access(CmdWrite, 16'hFFFF, 8'h3F, 1'b0);
    // window 3 back to ROM disables stores
    add_access(CmdWrite, 16'hA000, 8'h0E, 1'b0);
    add_access(CmdWrite, 16'hB555, 8'h77, 1'b0);

    for (int i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(99);
      data = 8'($urandom);
      if (kind < 25) begin
        // bank select: low 4KB of a switchable window
        cmd  = CmdWrite;
        addr = {RegionWin1 + 4'(2 * $urandom_range(2)), 12'($urandom)};
      end else if (kind < 45) begin
        cmd  = CmdWrite;
        addr = {RegionStore, 12'($urandom)};
      end else if (kind < 85) begin
        cmd  = CmdRead;
        addr = 16'($urandom_range(16'hBFFF, 16'h4000));
      end else begin
        cmd  = 1'($urandom);
        addr = 16'($urandom);
      end
      add_access(cmd, addr, data, (i % 400) == 0);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (access_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Driver: new transfer or idle at the falling edge
  always @(negedge clk_i) begin
    bit       load;
    pending_t nxt;
    out_ready_i <= rst_ni && !idle_now();
    if (rst_ni && (!in_valid_i || in_fire)) begin
      load = access_q.size() != 0 && !idle_now() &&
             !(access_q[0].drain_first && result_q.size() != 0);
      if (load) begin
        nxt = access_q.pop_front();
        in_item_i <= nxt.acc;
      end
      in_valid_i <= load;
    end
  end

  // Monitor: check results first, then predict the access taken this edge
  always @(posedge clk_i) begin
    map_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_item_o, 0);
      end else begin
        want = result_q.pop_front();
        if (out_item_o.target !== want.target)
          report_mismatch("target", out_item_o.target, want.target);
        if (out_item_o.rom_address !== want.rom_address)
          report_mismatch("rom_address", out_item_o.rom_address, want.rom_address);
        if (out_item_o.sram_address !== want.sram_address)
          report_mismatch("sram_address", out_item_o.sram_address, want.sram_address);
        if (out_item_o.sram_write !== want.sram_write)
          report_mismatch("sram_write", out_item_o.sram_write, want.sram_write);
        if (out_item_o.sram_data !== want.sram_data)
          report_mismatch("sram_data", out_item_o.sram_data, want.sram_data);
      end
    end
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) begin
      result_q.push_back(map_access(in_item_i));
    end
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
